>>> hw/rtl/tsfs_pkg.sv
// Shared types and constants for the touch sample filter and scaler.
// Used by the register bank, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package tsfs_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_X_OFFSET       = 3'd0;
    localparam logic [2:0] REG_X_SPAN         = 3'd1;
    localparam logic [2:0] REG_Y_OFFSET       = 3'd2;
    localparam logic [2:0] REG_Y_SPAN         = 3'd3;
    localparam logic [2:0] REG_X_PIXELS       = 3'd4;
    localparam logic [2:0] REG_Y_PIXELS       = 3'd5;
    localparam logic [2:0] REG_READ_COUNT     = 3'd6;
    localparam logic [2:0] REG_PAIR_THRESHOLD = 3'd7;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 17;

    // Divider geometry: |f - offset| * pixels stays below 2^29.
    localparam int DivNumW   = 30;
    localparam int DivDenW   = 17;
    localparam int DivCntW   = 5;
    localparam logic [DivCntW-1:0] DIV_STEPS = 5'd30;

    localparam logic [12:0] PIXELS_MAX = 13'd4096;

    typedef struct packed {
        logic signed [16:0] x_offset;
        logic signed [16:0] x_span;
        logic signed [16:0] y_offset;
        logic signed [16:0] y_span;
        logic [12:0]        x_pixels;
        logic [12:0]        y_pixels;
        logic [7:0]         read_count;
        logic [15:0]        pair_threshold;
    } cfg_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic commit;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic div_done;
        logic need_result;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/tsfs_cfg_regs.sv
// Configuration register bank for the touch sample filter and scaler.
// Depends on tsfs_pkg for the register indexes and the cfg_t layout.
`default_nettype none

module tsfs_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [tsfs_pkg::CfgIndexW-1:0]     wr_index,
    input  wire logic [tsfs_pkg::CfgDataW-1:0]      wr_data,
    output tsfs_pkg::cfg_t                          cfg
);

    tsfs_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_offset       <= 17'sd30960;
            cfg_reg.x_span         <= 17'sd1816;
            cfg_reg.y_offset       <= -17'sd29692;
            cfg_reg.y_span         <= 17'sd29684;
            cfg_reg.x_pixels       <= 13'd320;
            cfg_reg.y_pixels       <= 13'd240;
            cfg_reg.read_count     <= 8'd10;
            cfg_reg.pair_threshold <= 16'd3;
        end
        else if (wr_en)
        begin
            case (wr_index)
                tsfs_pkg::REG_X_OFFSET:       cfg_reg.x_offset       <= wr_data;
                tsfs_pkg::REG_X_SPAN:         cfg_reg.x_span         <= wr_data;
                tsfs_pkg::REG_Y_OFFSET:       cfg_reg.y_offset       <= wr_data;
                tsfs_pkg::REG_Y_SPAN:         cfg_reg.y_span         <= wr_data;
                tsfs_pkg::REG_X_PIXELS:       cfg_reg.x_pixels       <= wr_data[12:0];
                tsfs_pkg::REG_Y_PIXELS:       cfg_reg.y_pixels       <= wr_data[12:0];
                tsfs_pkg::REG_READ_COUNT:     cfg_reg.read_count     <= wr_data[7:0];
                tsfs_pkg::REG_PAIR_THRESHOLD: cfg_reg.pair_threshold <= wr_data[15:0];
                default:                      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tsfs_ctrl.sv
// Sequencing state machine for the touch sample filter and scaler.
// Depends on tsfs_pkg for the command and status structs.
`default_nettype none

module tsfs_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire tsfs_pkg::sts_t  sts,
    output tsfs_pkg::cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Wait here only when a result is due and the output is still full.
                if (!sts.need_result || sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/tsfs_datapath.sv
// Datapath of the touch sample filter and scaler: pair filter, offset and
// pixel multiply, serial signed divider, clamp, running mean and output register.
// Depends on tsfs_pkg for the cfg_t, cmd_t and sts_t types and divider sizes.
`default_nettype none

module tsfs_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tsfs_pkg::cfg_t  cfg,
    input  wire tsfs_pkg::cmd_t  cmd,
    output tsfs_pkg::sts_t       sts,
    input  wire logic [15:0]     in_s1,
    input  wire logic [15:0]     in_s2,
    input  wire logic [15:0]     in_s3,
    input  wire logic            in_axis,
    input  wire logic            in_down,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [11:0]          out_coord,
    output logic                 out_failed,
    output logic                 out_axis
);

    localparam int NW = tsfs_pkg::DivNumW;
    localparam int DW = tsfs_pkg::DivDenW;

    // Captured item.
    logic [15:0] s1_reg, s2_reg, s3_reg;
    logic        axis_reg, down_reg;

    // Values set up in the multiply cycle.
    logic [12:0]   size_reg;
    logic          good_reg;
    logic          neg_reg;
    logic [DW-1:0] dvs_reg;

    // Divider.
    logic [NW-1:0]                  quo_reg, quo_next;
    logic [DW-1:0]                  rem_reg, rem_next;
    logic [tsfs_pkg::DivCntW-1:0]   cnt_reg;

    // Window state.
    logic [11:0] mean_reg;
    logic        mean_valid_reg;
    logic [7:0]  reads_reg;

    // Output register.
    logic        out_valid_reg;
    logic [11:0] out_coord_reg;
    logic        out_failed_reg;
    logic        out_axis_reg;

    // Pair filter and multiply operands.
    logic [15:0]        d12, d13, d23;
    logic [16:0]        sum12, sum13, sum23;
    logic [15:0]        filt;
    logic               pair_ok;
    logic signed [16:0] sel_off, sel_span;
    logic [12:0]        sel_pix, size_c;
    logic signed [17:0] diff_s;
    logic signed [31:0] prod_s;
    logic [31:0]        prod_mag;
    logic [DW-1:0]      span_mag;

    always_comb
    begin
        d12   = (s1_reg > s2_reg) ? s1_reg - s2_reg : s2_reg - s1_reg;
        d13   = (s1_reg > s3_reg) ? s1_reg - s3_reg : s3_reg - s1_reg;
        d23   = (s2_reg > s3_reg) ? s2_reg - s3_reg : s3_reg - s2_reg;
        sum12 = {1'b0, s1_reg} + {1'b0, s2_reg};
        sum13 = {1'b0, s1_reg} + {1'b0, s3_reg};
        sum23 = {1'b0, s2_reg} + {1'b0, s3_reg};
        pair_ok = 1'b1;
        if (d12 < cfg.pair_threshold)
        begin
            filt = sum12[16:1];
        end
        else if (d13 < cfg.pair_threshold)
        begin
            filt = sum13[16:1];
        end
        else if (d23 < cfg.pair_threshold)
        begin
            filt = sum23[16:1];
        end
        else
        begin
            filt    = 16'd0;
            pair_ok = 1'b0;
        end

        sel_off  = axis_reg ? cfg.y_offset : cfg.x_offset;
        sel_span = axis_reg ? cfg.y_span : cfg.x_span;
        sel_pix  = axis_reg ? cfg.y_pixels : cfg.x_pixels;
        if (sel_pix == 13'd0)
        begin
            size_c = 13'd1;
        end
        else if (sel_pix > tsfs_pkg::PIXELS_MAX)
        begin
            size_c = tsfs_pkg::PIXELS_MAX;
        end
        else
        begin
            size_c = sel_pix;
        end

        diff_s   = $signed({2'b00, filt}) - $signed({sel_off[16], sel_off});
        prod_s   = diff_s * $signed({1'b0, size_c});
        prod_mag = prod_s[31] ? 32'(-prod_s) : 32'(prod_s);
        span_mag = sel_span[16] ? DW'(-sel_span) : DW'(sel_span);
    end

    // One restoring division step.
    logic [DW:0] rem_shift, rem_sub;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NW-1]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        if (rem_shift >= {1'b0, dvs_reg})
        begin
            rem_next = rem_sub[DW-1:0];
            quo_next = {quo_reg[NW-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift[DW-1:0];
            quo_next = {quo_reg[NW-2:0], 1'b0};
        end
    end

    // Sign, minus one, clamp, running mean and window bookkeeping.
    logic signed [31:0] q_s, r_s;
    logic [11:0]        size_m1, coord;
    logic [12:0]        mean_sum;
    logic [11:0]        mean_upd;
    logic [7:0]         limit, reads_inc;
    logic               window_end;

    always_comb
    begin
        q_s = $signed({2'b00, quo_reg});
        if (neg_reg)
        begin
            q_s = -q_s;
        end
        r_s     = q_s - 32'sd1;
        size_m1 = 12'(size_reg - 13'd1);
        if (r_s[31])
        begin
            coord = 12'd0;
        end
        else if (r_s > $signed({20'd0, size_m1}))
        begin
            coord = size_m1;
        end
        else
        begin
            coord = r_s[11:0];
        end

        mean_sum = {1'b0, mean_reg} + {1'b0, coord};
        mean_upd = mean_valid_reg ? mean_sum[12:1] : coord;

        limit      = (cfg.read_count == 8'd0) ? 8'd1 : cfg.read_count;
        reads_inc  = reads_reg + 8'd1;
        window_end = reads_inc >= limit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s1_reg   <= in_s1;
            s2_reg   <= in_s2;
            s3_reg   <= in_s3;
            axis_reg <= in_axis;
            down_reg <= in_down;
        end
        if (cmd.mul)
        begin
            size_reg <= size_c;
            good_reg <= pair_ok && (filt != 16'd0) && (sel_span != 17'sd0);
            neg_reg  <= prod_s[31] ^ sel_span[16];
            dvs_reg  <= span_mag;
            quo_reg  <= prod_mag[NW-1:0];
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        // The output fields change only when a result is loaded, so a result that
        // waits for the sink stays intact while reads that close no window commit.
        if (cmd.commit && sts.need_result)
        begin
            out_axis_reg <= axis_reg;
            if (!down_reg)
            begin
                out_coord_reg  <= 12'd0;
                out_failed_reg <= 1'b1;
            end
            else if (mean_valid_reg || good_reg)
            begin
                out_coord_reg  <= good_reg ? mean_upd : mean_reg;
                out_failed_reg <= 1'b0;
            end
            else
            begin
                out_coord_reg  <= 12'd0;
                out_failed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            mean_reg       <= '0;
            mean_valid_reg <= 1'b0;
            reads_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.mul)
            begin
                cnt_reg <= tsfs_pkg::DIV_STEPS;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end

            if (cmd.commit && sts.need_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.commit)
            begin
                if (!down_reg || window_end)
                begin
                    mean_reg       <= '0;
                    mean_valid_reg <= 1'b0;
                    reads_reg      <= '0;
                end
                else
                begin
                    reads_reg <= reads_inc;
                    if (good_reg)
                    begin
                        mean_reg       <= mean_upd;
                        mean_valid_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign sts.div_done    = (cnt_reg == tsfs_pkg::DivCntW'(1));
    assign sts.need_result = !down_reg || window_end;
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_coord  = out_coord_reg;
    assign out_failed = out_failed_reg;
    assign out_axis   = out_axis_reg;

endmodule

`default_nettype wire

>>> hw/rtl/touch_sample_filter_scale.sv
// Top level of the touch sample filter and scaler.
// Depends on tsfs_pkg, tsfs_cfg_regs, tsfs_ctrl and tsfs_datapath.
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  one read: three raw samples, axis, pressed state
// m_*       out        m_tvalid/m_tready  one measurement: coordinate, failed, axis
// cfg_*     in         cfg_valid/cfg_ready register index and write data
//
// Each transaction passes through its capture, a multiply, 30 steps of the shared
// one-bit-per-cycle restoring divider and a commit before the next one is accepted.
// Results wait in an output register while the next transaction is taken; only a second
// result due while the first is unread stalls the commit. Reset clears the window state
// and the output valid, the registers take their reset values, and cfg_ready stays high.
`default_nettype none

module touch_sample_filter_scale (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [15:0] sample_first, [31:16] sample_second, [47:32] sample_third
    input  wire logic [47:0]                     s_tdata,
    // [0] axis, [1] touch_down
    input  wire logic [1:0]                      s_tuser,

    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [11:0] coordinate, [15:12] zero fill
    output logic [15:0]                          m_tdata,
    // [0] failed, [1] axis_out
    output logic [1:0]                           m_tuser,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tsfs_pkg::CfgIndexW-1:0]  cfg_index,
    input  wire logic [tsfs_pkg::CfgDataW-1:0]   cfg_data
);

    tsfs_pkg::cfg_t cfg;
    tsfs_pkg::cmd_t cmd;
    tsfs_pkg::sts_t sts;

    logic [11:0] coord;

    // Writes are accepted in any cycle; software must write only while idle, and the block itself does not enforce it.
    assign cfg_ready = 1'b1;

    tsfs_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tsfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tsfs_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .sts        (sts),
        .in_s1      (s_tdata[15:0]),
        .in_s2      (s_tdata[31:16]),
        .in_s3      (s_tdata[47:32]),
        .in_axis    (s_tuser[0]),
        .in_down    (s_tuser[1]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_coord  (coord),
        .out_failed (m_tuser[0]),
        .out_axis   (m_tuser[1])
    );

    assign m_tdata = {4'd0, coord};

    // A transaction keeps the block busy for the following cycle.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready
    ) else $error("input accepted while the previous item is still in work");

    // A failed measurement carries a zero coordinate.
    a_failed_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0
    ) else $error("failed result with nonzero coordinate");

    // A due result is committed only when the output register can take it.
    a_commit_room: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.commit && sts.need_result |-> sts.out_free
    ) else $error("result committed over an unread result");

    // The divider finishes before the commit and never runs from idle.
    a_div_in_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !s_tready
    ) else $error("divider stepping while the block is idle");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for touch_sample_filter_scale.
// Depends on tsfs_pkg and the RTL of the block; it needs no other files.

module tb_top;

    // Time the block needs per read, from acceptance until it takes the next one, when the commit does not stall.
    localparam int ITEM_CYCLES = 33;

    // One read as it travels on the slave stream.
    typedef struct packed {
        logic [15:0] s1;
        logic [15:0] s2;
        logic [15:0] s3;
        logic        axis;
        logic        down;
    } touch_read_t;

    // One measurement as it leaves on the master stream.
    typedef struct packed {
        logic [11:0] coord;
        logic        failed;
        logic        axis;
    } meas_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [47:0]                    s_tdata = '0;
    logic [1:0]                     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [15:0]                    m_tdata;
    logic [1:0]                     m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tsfs_pkg::CfgIndexW-1:0] cfg_index = '0;
    logic [tsfs_pkg::CfgDataW-1:0]  cfg_data = '0;

    touch_sample_filter_scale u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Reads waiting to be driven, and the measurements the block owes us, oldest first.
    touch_read_t pending_reads[$];
    meas_t       expected_meas[$];
    touch_read_t on_bus;

    // Our own copy of the calibration registers, updated when a register write
    // transaction completes. It starts from the documented reset values.
    tsfs_pkg::cfg_t cal = '{
        x_offset:       17'sd30960,
        x_span:         17'sd1816,
        y_offset:       -17'sd29692,
        y_span:         17'sd29684,
        x_pixels:       13'd320,
        y_pixels:       13'd240,
        read_count:     8'd10,
        pair_threshold: 16'd3
    };

    // Measurement window state of the predictor.
    logic [11:0] win_mean = '0;
    logic        win_has_good = 1'b0;
    logic [7:0]  win_reads = '0;

    bit calm = 1'b0;       // set for the closing phase: no idling on either side
    int send_gap = 0;
    int stall_left = 0;
    int mismatches = 0;
    int reads_accepted = 0;
    int meas_checked = 0;
    int meas_failed = 0;
    int settings_written = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A pair counts as close when its samples differ by less than the threshold;
    // the mean of a close pair is the truncated average.
    function automatic bit close_pair(input logic [15:0] a, input logic [15:0] b,
                                      output logic [15:0] mean);
        int ia;
        int ib;
        int thr;
        logic [16:0] sum;
        ia = a;
        ib = b;
        thr = cal.pair_threshold;
        sum = {1'b0, a} + {1'b0, b};
        mean = sum[16:1];
        return ((ia > ib) ? ia - ib : ib - ia) < thr;
    endfunction

    // Pairs are tried in the order first-second, first-third, second-third.
    // Zero means no usable pair, and a mean of zero is treated the same way.
    function automatic logic [15:0] pair_mean(input touch_read_t rd);
        logic [15:0] m;
        if (close_pair(rd.s1, rd.s2, m)) return m;
        if (close_pair(rd.s1, rd.s3, m)) return m;
        if (close_pair(rd.s2, rd.s3, m)) return m;
        return 16'd0;
    endfunction

    // Maps the filtered value onto the screen: (f - offset) * pixels / span - 1,
    // with signed division truncating toward zero, then clamped to the screen.
    function automatic bit calibrate_read(input touch_read_t rd, output logic [11:0] coord);
        logic [15:0] f;
        longint off;
        longint span;
        longint npix;
        longint r;
        coord = '0;
        f = pair_mean(rd);
        off = rd.axis ? $signed(cal.y_offset) : $signed(cal.x_offset);
        span = rd.axis ? $signed(cal.y_span) : $signed(cal.x_span);
        npix = rd.axis ? cal.y_pixels : cal.x_pixels;
        // Pixel counts outside 1..4096 are pulled back into that range.
        if (npix < 1) npix = 1;
        if (npix > 4096) npix = 4096;
        if (f == 16'd0 || span == 0) return 1'b0;
        r = (longint'(f) - off) * npix / span - 1;
        if (r < 0) r = 0;
        if (r > npix - 1) r = npix - 1;
        coord = r[11:0];
        return 1'b1;
    endfunction

    // Folds one accepted read into the window and says whether it closes a
    // measurement, and with what fields.
    task automatic predict_measurement(input touch_read_t rd, output bit emits,
                                       output meas_t m);
        logic [11:0] coord;
        logic [12:0] sum;
        logic [7:0]  limit;
        emits = 1'b0;
        m = '0;
        m.axis = rd.axis;
        // A window length of zero behaves as one read per measurement.
        limit = (cal.read_count == 8'd0) ? 8'd1 : cal.read_count;
        if (!rd.down) begin
            // Release: samples are ignored, the window restarts, a failure is reported.
            win_mean = '0;
            win_has_good = 1'b0;
            win_reads = '0;
            m.failed = 1'b1;
            emits = 1'b1;
        end
        else begin
            if (calibrate_read(rd, coord)) begin
                sum = {1'b0, win_mean} + {1'b0, coord};
                win_mean = win_has_good ? sum[12:1] : coord;
                win_has_good = 1'b1;
            end
            win_reads = win_reads + 8'd1;
            if (win_reads >= limit) begin
                emits = 1'b1;
                m.coord = win_has_good ? win_mean : 12'd0;
                m.failed = !win_has_good;
                win_mean = '0;
                win_has_good = 1'b0;
                win_reads = '0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_read(input logic [15:0] s1, input logic [15:0] s2,
                             input logic [15:0] s3, input logic axis, input logic down);
        touch_read_t rd;
        rd.s1 = s1;
        rd.s2 = s2;
        rd.s3 = s3;
        rd.axis = axis;
        rd.down = down;
        pending_reads.push_back(rd);
    endtask

    // Builds a read that usually lands inside the calibrated window of its axis,
    // with one close pair chosen at random, or none, or a zero mean.
    function automatic touch_read_t make_read(input logic axis, input logic down);
        touch_read_t rd;
        longint off;
        longint span;
        longint frac;
        longint base;
        longint near;
        int thr;
        int d;
        off = axis ? $signed(cal.y_offset) : $signed(cal.x_offset);
        span = axis ? $signed(cal.y_span) : $signed(cal.x_span);
        frac = $urandom_range(0, 1100);
        if ($urandom_range(0, 2) == 0) base = $urandom_range(0, 65535);
        else base = off + span * frac / 1024;
        if (base < 0) base = 0;
        if (base > 65535) base = 65535;
        thr = cal.pair_threshold;
        d = (thr > 0) ? int'($urandom_range(0, thr - 1)) : 0;
        near = (base + d > 65535) ? base - d : base + d;
        rd.s1 = base[15:0];
        rd.s2 = 16'($urandom);
        rd.s3 = 16'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: rd.s2 = near[15:0];
            4, 5:       rd.s3 = near[15:0];
            6, 7:
            begin
                rd.s1 = 16'($urandom);
                rd.s2 = base[15:0];
                rd.s3 = near[15:0];
            end
            8:          rd.s1 = 16'($urandom);
            default:
            begin
                // Mean of zero: both samples at zero, or zero and one.
                rd.s1 = 16'd0;
                rd.s2 = 16'($urandom_range(0, 1));
            end
        endcase
        rd.axis = axis;
        rd.down = down;
        return rd;
    endfunction

    // Queues reads in runs of one axis, with the odd stray axis and, when
    // release_odds is nonzero, a release about once in that many reads.
    task automatic add_reads(input int count, input int release_odds);
        logic axis;
        logic down;
        int run_left;
        axis = 1'b0;
        run_left = 0;
        for (int i = 0; i < count; i++) begin
            if (run_left == 0) begin
                axis = 1'($urandom);
                run_left = $urandom_range(1, 16);
            end
            run_left--;
            down = (release_odds == 0) || ($urandom_range(1, release_odds) != 1);
            pending_reads.push_back(make_read(axis ^ ($urandom_range(0, 9) == 0), down));
        end
    endtask

    // Register write transaction. The shadow copy follows the width of each register.
    task automatic cfg_write(input logic [tsfs_pkg::CfgIndexW-1:0] idx,
                             input logic [tsfs_pkg::CfgDataW-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            tsfs_pkg::REG_X_OFFSET:       cal.x_offset = value;
            tsfs_pkg::REG_X_SPAN:         cal.x_span = value;
            tsfs_pkg::REG_Y_OFFSET:       cal.y_offset = value;
            tsfs_pkg::REG_Y_SPAN:         cal.y_span = value;
            tsfs_pkg::REG_X_PIXELS:       cal.x_pixels = value[12:0];
            tsfs_pkg::REG_Y_PIXELS:       cal.y_pixels = value[12:0];
            tsfs_pkg::REG_READ_COUNT:     cal.read_count = value[7:0];
            tsfs_pkg::REG_PAIR_THRESHOLD: cal.pair_threshold = value[15:0];
            default:                      ;
        endcase
        settings_written++;
    endtask

    // Narrow registers get random bits above their width, which must be dropped.
    function automatic logic [tsfs_pkg::CfgDataW-1:0] with_junk(
            input logic [tsfs_pkg::CfgDataW-1:0] v, input int w);
        logic [tsfs_pkg::CfgDataW-1:0] keep;
        keep = (17'd1 << w) - 17'd1;
        return (17'($urandom) & ~keep) | (v & keep);
    endfunction

    task automatic write_all(input logic [16:0] xo, input logic [16:0] xs,
                             input logic [16:0] yo, input logic [16:0] ys,
                             input logic [12:0] xp, input logic [12:0] yp,
                             input logic [7:0] rc, input logic [15:0] thr);
        cfg_write(tsfs_pkg::REG_X_OFFSET, xo);
        cfg_write(tsfs_pkg::REG_X_SPAN, xs);
        cfg_write(tsfs_pkg::REG_Y_OFFSET, yo);
        cfg_write(tsfs_pkg::REG_Y_SPAN, ys);
        cfg_write(tsfs_pkg::REG_X_PIXELS, with_junk({4'd0, xp}, 13));
        cfg_write(tsfs_pkg::REG_Y_PIXELS, with_junk({4'd0, yp}, 13));
        cfg_write(tsfs_pkg::REG_READ_COUNT, with_junk({9'd0, rc}, 8));
        cfg_write(tsfs_pkg::REG_PAIR_THRESHOLD, with_junk({1'b0, thr}, 16));
    endtask

    // A random calibration: mostly a plausible window of either sign, sometimes
    // arbitrary words or a zero span; screen sizes and window lengths vary too.
    task automatic random_setup(input bit zero_threshold);
        logic [16:0] off[2];
        logic [16:0] spn[2];
        logic [12:0] px[2];
        logic [7:0]  rc;
        logic [15:0] thr;
        for (int a = 0; a < 2; a++) begin
            case ($urandom_range(0, 9))
                0:
                begin
                    off[a] = 17'($urandom);
                    spn[a] = 17'($urandom);
                end
                1:
                begin
                    off[a] = 17'($urandom_range(0, 65535));
                    spn[a] = '0;
                end
                default:
                begin
                    off[a] = 17'($urandom_range(0, 30000));
                    spn[a] = 17'($urandom_range(500, 35000));
                    if ($urandom_range(0, 3) == 0) begin
                        off[a] = off[a] + spn[a];
                        spn[a] = -spn[a];
                    end
                end
            endcase
            case ($urandom_range(0, 11))
                0:       px[a] = 13'd0;
                1:       px[a] = 13'd1;
                2:       px[a] = 13'd4096;
                3:       px[a] = 13'($urandom);
                default: px[a] = 13'($urandom_range(1, 4096));
            endcase
        end
        case ($urandom_range(0, 9))
            0:       rc = 8'd0;
            1:       rc = 8'd1;
            default: rc = 8'($urandom_range(2, 12));
        endcase
        case ($urandom_range(0, 9))
            0:       thr = 16'hFFFF;
            1:       thr = 16'($urandom);
            2:       thr = 16'd1;
            default: thr = 16'($urandom_range(2, 64));
        endcase
        if (zero_threshold) thr = 16'd0;
        write_all(off[0], spn[0], off[1], spn[1], px[0], px[1], rc, thr);
    endtask

    // Waits until every read is taken and every measurement has come, then gives
    // the block time to finish a read that closes no window.
    task automatic settle();
        do @(negedge clk);
        while (pending_reads.size() != 0 || s_tvalid || expected_meas.size() != 0);
        repeat (ITEM_CYCLES + 8) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: one read transaction at a time from pending_reads. The
    // prediction is made when the transaction completes, so it always uses
    // the calibration that was in force at that moment.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else begin : drive
            bit    emits;
            meas_t want;
            if (s_tvalid && s_tready) begin
                predict_measurement(on_bus, emits, want);
                if (emits) expected_meas.push_back(want);
                reads_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reads.size() == 0) begin
                    s_tvalid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 7) == 0) begin
                    // Start an idle burst that includes this cycle.
                    send_gap = $urandom_range(0, 13);
                    s_tvalid <= 1'b0;
                end
                else begin
                    on_bus = pending_reads.pop_front();
                    s_tdata <= {on_bus.s3, on_bus.s2, on_bus.s1};
                    s_tuser <= {on_bus.down, on_bus.axis};
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each measurement transaction against the oldest
    // expectation and applies back-pressure in random bursts.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin : watch
            meas_t want;
            meas_t got;
            if (m_tvalid && m_tready) begin
                got.coord = m_tdata[11:0];
                got.failed = m_tuser[0];
                got.axis = m_tuser[1];
                if (expected_meas.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: measurement with none expected: %s",
                                 $realtime,
                                 $sformatf("coord=%0d failed=%0b axis=%0b",
                                           got.coord, got.failed, got.axis));
                    mismatches++;
                end
                else begin
                    want = expected_meas.pop_front();
                    meas_checked++;
                    if (want.failed) meas_failed++;
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("%0t: measurement %0d: expected %s, got %s",
                                     $realtime, meas_checked,
                                     $sformatf("coord=%0d failed=%0b axis=%0b",
                                               want.coord, want.failed, want.axis),
                                     $sformatf("coord=%0d failed=%0b axis=%0b",
                                               got.coord, got.failed, got.axis));
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 13);
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed reads under the reset calibration (x: 30960 + 1816 over 320 pixels,
        // window of 10, threshold 3). A release opens the run.
        push_read(16'd1234, 16'd1234, 16'd1234, 1'b0, 1'b0);
        // A full window of ten reads covering each filter path and both clamps.
        push_read(16'd0, 16'd0, 16'd0, 1'b0, 1'b1);             // mean zero
        push_read(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);    // top of range
        push_read(16'd31868, 16'd31869, 16'd0, 1'b0, 1'b1);    // first pair close
        push_read(16'd31000, 16'd40000, 16'd31002, 1'b0, 1'b1); // first and third
        push_read(16'd100, 16'd32000, 16'd32001, 1'b1, 1'b1);  // second and third
        push_read(16'd0, 16'd10000, 16'd20000, 1'b0, 1'b1);    // no pair close
        push_read(16'd30960, 16'd30960, 16'd5, 1'b0, 1'b1);    // at the origin
        push_read(16'd1000, 16'd1001, 16'd9, 1'b0, 1'b1);      // below the origin
        push_read(16'd500, 16'd503, 16'd9000, 1'b0, 1'b1);     // difference equals threshold
        push_read(16'd31500, 16'd31502, 16'd9000, 1'b1, 1'b1); // closes the window on y
        // A y window broken off by a release.
        push_read(16'd1, 16'd2, 16'd40000, 1'b1, 1'b1);
        push_read(16'd20000, 16'd20001, 16'd0, 1'b1, 1'b1);
        push_read(16'd7, 16'd50000, 16'd60000, 1'b1, 1'b1);
        push_read(16'hFFFF, 16'h0000, 16'hAAAA, 1'b1, 1'b0);
        // A window where no read is good: it must end as a failure.
        for (int i = 0; i < 10; i++)
            push_read(16'(i * 7000), 16'(i * 7000 + 3000), 16'(i * 7000 + 6000),
                      1'(i % 2), 1'b1);
        settle();

        // Register extremes: zero x span, y origin at the bottom of the signed range,
        // screen sizes out of range, a window length of zero and the widest threshold.
        write_all(17'd0, 17'd0, 17'h10000, 17'h0FFFF, 13'd0, 13'd8191, 8'd0, 16'hFFFF);
        add_reads(20, 8);
        settle();

        // The other ends: a negative x span, one-pixel and full screens, one read per
        // window, and a threshold that only accepts identical samples.
        write_all(17'h0FFFF, 17'h10000, 17'h1FFFF, 17'd1, 13'd4096, 13'd1, 8'd1, 16'd1);
        add_reads(15, 8);
        settle();

        // Random calibrations, each with a batch of reads; one of them filters everything out.
        for (int p = 0; p < 8; p++) begin
            random_setup(p == 3);
            add_reads(55, 20);
            settle();
        end

        // The longest window, with no release to cut it short.
        random_setup(1'b0);
        cfg_write(tsfs_pkg::REG_READ_COUNT, with_junk(17'd255, 8));
        cfg_write(tsfs_pkg::REG_PAIR_THRESHOLD, with_junk(17'd40, 16));
        add_reads(258, 0);
        push_read(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, 1'b0);
        settle();

        // Closing phase at full rate on both sides.
        calm = 1'b1;
        random_setup(1'b0);
        add_reads(60, 20);
        settle();

        $display("Sent %0d reads across %0d register writes; checked %0d measurements,",
                 reads_accepted, settings_written, meas_checked);
        $display("%0d of them failures, with %0d mismatches and %0d measurements missing.",
                 meas_failed, mismatches, expected_meas.size());
        if (mismatches == 0 && expected_meas.size() == 0) begin
            $display("*** PASSED ***");
        end
        else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timeout with %0d reads pending and %0d measurements outstanding.",
                 pending_reads.size(), expected_meas.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
